>>> rtl/core/mfep_pkg.sv
// ----------------------------------------------------------------------------
// MIDI file event parser package
// Shared types, phase codes and constants for the parser core.
// ----------------------------------------------------------------------------
package mfep_pkg;

    localparam int VARLEN_MAX_BYTES_DEF = 4;
    localparam int QUEUE_DEPTH          = 4;

    localparam logic [2:0] KIND_CHANNEL  = 3'd0;
    localparam logic [2:0] KIND_TEMPO    = 3'd1;
    localparam logic [2:0] KIND_HDR_OK   = 3'd2;
    localparam logic [2:0] KIND_TRK_DONE = 3'd3;
    localparam logic [2:0] KIND_COMPLETE = 3'd4;
    localparam logic [2:0] KIND_BAD_HDR  = 3'd5;
    localparam logic [2:0] KIND_TIMECODE = 3'd6;

    localparam logic [4:0] PH_HDR_ID    = 5'd0;
    localparam logic [4:0] PH_HDR_LEN   = 5'd1;
    localparam logic [4:0] PH_FORMAT    = 5'd2;
    localparam logic [4:0] PH_NTRK      = 5'd3;
    localparam logic [4:0] PH_DIV       = 5'd4;
    localparam logic [4:0] PH_TRK_ID    = 5'd5;
    localparam logic [4:0] PH_TRK_LEN   = 5'd6;
    localparam logic [4:0] PH_DELTA     = 5'd7;
    localparam logic [4:0] PH_STATUS    = 5'd8;
    localparam logic [4:0] PH_META_TYPE = 5'd9;
    localparam logic [4:0] PH_META_LEN  = 5'd10;
    localparam logic [4:0] PH_META_DATA = 5'd11;
    localparam logic [4:0] PH_SYSEX_LEN = 5'd12;
    localparam logic [4:0] PH_SKIP      = 5'd13;
    localparam logic [4:0] PH_DATA1     = 5'd14;
    localparam logic [4:0] PH_DATA2     = 5'd15;
    localparam logic [4:0] PH_IDLE      = 5'd16;

    localparam logic [7:0]  META_TEMPO = 8'h51;
    localparam logic [7:0]  META_EOT   = 8'h2F;
    localparam logic [7:0]  ST_META    = 8'hFF;
    localparam logic [7:0]  ST_SYSEX   = 8'hF0;
    localparam logic [7:0]  ST_SYSEX_E = 8'hF7;
    localparam logic [3:0]  HI_PROG    = 4'hC;
    localparam logic [3:0]  HI_PRESS   = 4'hD;
    localparam logic [23:0] TEMPO_DEF  = 24'd500000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [31:0] event_tick;
        logic [7:0]  status_byte;
        logic [7:0]  first_data;
        logic [7:0]  second_data;
        logic [23:0] tempo_value;
        logic [15:0] header_value;
        logic        last_result;
    } t_out_item;

    // Up to three results per byte, packed into one queue entry.
    typedef struct packed {
        logic [1:0]  count;
        t_out_item   r0;
        t_out_item   r1;
        t_out_item   r2;
    } t_res_group;

    function automatic logic [7:0] hdr_char(input logic [1:0] idx);
        case (idx)
            2'd0:    hdr_char = 8'h4D;
            2'd1:    hdr_char = 8'h54;
            2'd2:    hdr_char = 8'h68;
            default: hdr_char = 8'h64;
        endcase
    endfunction

    function automatic logic [7:0] trk_char(input logic [1:0] idx);
        case (idx)
            2'd0:    trk_char = 8'h4D;
            2'd1:    trk_char = 8'h54;
            2'd2:    trk_char = 8'h72;
            default: trk_char = 8'h6B;
        endcase
    endfunction

endpackage

>>> rtl/core/mfep_front.sv
// ----------------------------------------------------------------------------
// MIDI file parser front end
// Takes one file byte per cycle while i_take is high, steps the parser state and builds the group
// of results that the byte causes.
// ----------------------------------------------------------------------------
module mfep_front #(
    parameter int VARLEN_MAX_BYTES = mfep_pkg::VARLEN_MAX_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  mfep_pkg::t_in_item    i_item,
    output mfep_pkg::t_res_group  o_group
);

    logic [4:0]  r_phase, n_phase;
    logic [2:0]  r_fcnt, n_fcnt;
    logic [7:0]  r_run, n_run;
    logic [7:0]  r_cur, n_cur;
    logic [7:0]  r_held, n_held;
    logic [31:0] r_tick, n_tick;
    logic [31:0] r_max, n_max;
    logic [27:0] r_vacc, n_vacc;
    logic [31:0] r_left, n_left;
    logic [15:0] r_trks, n_trks;
    logic [27:0] r_skip, n_skip;
    logic [7:0]  r_meta, n_meta;
    logic [23:0] r_tempo, n_tempo;

    mfep_pkg::t_out_item  res [3];
    logic [1:0]           nres;

    always_comb begin
        logic [7:0]  b;
        logic [27:0] va;
        logic [2:0]  vc;
        logic        vdone;
        logic [32:0] sum;
        logic [15:0] w;
        logic        again;
        logic [1:0]  pass;
        b       = i_item.data_byte;
        n_phase = r_phase; n_fcnt = r_fcnt; n_run = r_run; n_cur = r_cur;
        n_held  = r_held;  n_tick = r_tick; n_max = r_max; n_vacc = r_vacc;
        n_left  = r_left;  n_trks = r_trks; n_skip = r_skip; n_meta = r_meta;
        n_tempo = r_tempo;
        if (i_item.file_start) begin
            n_phase = mfep_pkg::PH_HDR_ID; n_fcnt = '0; n_run = '0; n_cur = '0;
            n_held = '0; n_tick = '0; n_max = '0; n_vacc = '0; n_left = '0;
            n_trks = '0; n_skip = '0; n_meta = '0; n_tempo = mfep_pkg::TEMPO_DEF;
        end
        nres = '0;
        for (int k = 0; k < 3; k++) res[k] = '0;
        va = '0; vc = '0; vdone = 1'b0; sum = '0; w = '0; again = 1'b0;

        case (n_phase)
            mfep_pkg::PH_HDR_ID: begin
                if (b != mfep_pkg::hdr_char(n_fcnt[1:0])) begin
                    res[nres].result_kind = mfep_pkg::KIND_BAD_HDR; nres = nres + 2'd1;
                    n_phase = mfep_pkg::PH_IDLE;
                end else if (n_fcnt == 3'd3) begin
                    n_fcnt = '0; n_phase = mfep_pkg::PH_HDR_LEN;
                end else begin
                    n_fcnt = n_fcnt + 3'd1;
                end
            end
            mfep_pkg::PH_HDR_LEN: begin
                if (n_fcnt == 3'd3) begin
                    n_fcnt = '0; n_phase = mfep_pkg::PH_FORMAT;
                end else n_fcnt = n_fcnt + 3'd1;
            end
            mfep_pkg::PH_FORMAT: begin
                if (n_fcnt == 3'd1) begin
                    n_fcnt = '0; n_phase = mfep_pkg::PH_NTRK;
                end else n_fcnt = n_fcnt + 3'd1;
            end
            mfep_pkg::PH_NTRK: begin
                n_trks = {n_trks[7:0], b};
                if (n_fcnt == 3'd1) begin
                    n_fcnt = '0; n_phase = mfep_pkg::PH_DIV;
                end else n_fcnt = n_fcnt + 3'd1;
            end
            mfep_pkg::PH_DIV: begin
                if (n_fcnt == 3'd0) begin
                    n_held = b; n_fcnt = 3'd1;
                end else begin
                    n_fcnt = '0;
                    w = {n_held, b};
                    n_held = '0;
                    if (w[15]) begin
                        res[nres].result_kind  = mfep_pkg::KIND_TIMECODE;
                        res[nres].header_value = w;
                        nres = nres + 2'd1;
                        n_phase = mfep_pkg::PH_IDLE;
                    end else begin
                        res[nres].result_kind  = mfep_pkg::KIND_HDR_OK;
                        res[nres].header_value = w;
                        nres = nres + 2'd1;
                        if (n_trks == '0) begin
                            res[nres].result_kind = mfep_pkg::KIND_COMPLETE;
                            res[nres].event_tick  = n_max;
                            nres = nres + 2'd1;
                            n_phase = mfep_pkg::PH_IDLE;
                        end else n_phase = mfep_pkg::PH_TRK_ID;
                    end
                end
            end
            mfep_pkg::PH_TRK_ID: begin
                if (b != mfep_pkg::trk_char(n_fcnt[1:0])) n_held = 8'd1;
                if (n_fcnt == 3'd3) begin
                    n_fcnt = '0;
                    if (n_held != '0) begin
                        n_held = '0;
                        n_trks = n_trks - 16'd1;
                        if (n_trks == '0) begin
                            res[nres].result_kind = mfep_pkg::KIND_COMPLETE;
                            res[nres].event_tick  = n_max;
                            nres = nres + 2'd1;
                            n_phase = mfep_pkg::PH_IDLE;
                        end else n_phase = mfep_pkg::PH_TRK_ID;
                    end else begin
                        n_left = '0; n_phase = mfep_pkg::PH_TRK_LEN;
                    end
                end else n_fcnt = n_fcnt + 3'd1;
            end
            mfep_pkg::PH_TRK_LEN: begin
                n_left = {n_left[23:0], b};
                if (n_fcnt == 3'd3) begin
                    n_fcnt = '0; n_tick = '0; n_run = '0; n_cur = '0;
                    again = 1'b1; // run the event boundary check below
                end else n_fcnt = n_fcnt + 3'd1;
            end
            mfep_pkg::PH_IDLE: begin
            end
            default: begin
                if (n_phase > mfep_pkg::PH_DATA2) n_phase = mfep_pkg::PH_IDLE;
                else if (n_left != '0) n_left = n_left - 32'd1;
            end
        endcase

        // Event boundary after a track length.
        if (again) begin
            again = 1'b0;
            if (n_left == '0) begin
                if (n_tick > n_max) n_max = n_tick;
                res[nres].result_kind = mfep_pkg::KIND_TRK_DONE;
                res[nres].event_tick  = n_tick;
                nres = nres + 2'd1;
                n_trks = n_trks - 16'd1;
                if (n_trks == '0) begin
                    res[nres].result_kind = mfep_pkg::KIND_COMPLETE;
                    res[nres].event_tick  = n_max;
                    nres = nres + 2'd1;
                    n_phase = mfep_pkg::PH_IDLE;
                end else begin
                    n_phase = mfep_pkg::PH_TRK_ID; n_fcnt = '0; n_held = '0;
                end
            end else begin
                n_phase = mfep_pkg::PH_DELTA; n_vacc = '0; n_fcnt = '0;
            end
        end

        // Track bytes: a data byte in status position is taken a second time.
        for (pass = 2'd0; pass < 2'd2; pass = pass + 2'd1) begin
            logic evend;
            logic trkend;
            logic meta_fin;
            evend = 1'b0; trkend = 1'b0; meta_fin = 1'b0;
            if (((pass == 2'd0) && !i_item.file_start ? 1'b1 : (pass == 2'd0)) &&
                (r_phase >= mfep_pkg::PH_DELTA) && (r_phase <= mfep_pkg::PH_DATA2) &&
                !i_item.file_start || (pass == 2'd1 && again)) begin
                again = 1'b0;
                va = {n_vacc[20:0], b[6:0]};
                vc = n_fcnt + 3'd1;
                vdone = !b[7] || (vc >= 3'(VARLEN_MAX_BYTES));
                case (n_phase)
                    mfep_pkg::PH_DELTA: begin
                        n_vacc = va; n_fcnt = vc;
                        if (vdone) begin
                            sum = {1'b0, n_tick} + {5'd0, va};
                            n_tick = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                            n_phase = mfep_pkg::PH_STATUS;
                        end
                    end
                    mfep_pkg::PH_STATUS: begin
                        if (b[7]) begin
                            n_run = b; n_cur = b;
                        end else n_cur = n_run;
                        if (n_cur == mfep_pkg::ST_META) n_phase = mfep_pkg::PH_META_TYPE;
                        else if (n_cur == mfep_pkg::ST_SYSEX ||
                                 n_cur == mfep_pkg::ST_SYSEX_E) begin
                            n_phase = mfep_pkg::PH_SYSEX_LEN; n_vacc = '0; n_fcnt = '0;
                        end else n_phase = mfep_pkg::PH_DATA1;
                        again = !b[7];
                    end
                    mfep_pkg::PH_META_TYPE: begin
                        n_meta = b; n_phase = mfep_pkg::PH_META_LEN;
                        n_vacc = '0; n_fcnt = '0;
                    end
                    mfep_pkg::PH_META_LEN: begin
                        n_vacc = va; n_fcnt = vc;
                        if (vdone) begin
                            n_skip = va;
                            if (n_meta == mfep_pkg::META_TEMPO && va < 28'd3) n_meta = '0;
                            n_tempo = '0; n_fcnt = '0;
                            if (va == '0) meta_fin = 1'b1;
                            else n_phase = mfep_pkg::PH_META_DATA;
                        end
                    end
                    mfep_pkg::PH_META_DATA: begin
                        if (n_meta == mfep_pkg::META_TEMPO && n_fcnt < 3'd3) begin
                            n_tempo = {n_tempo[15:0], b}; n_fcnt = n_fcnt + 3'd1;
                        end
                        n_skip = n_skip - 28'd1;
                        if (n_skip == '0) meta_fin = 1'b1;
                    end
                    mfep_pkg::PH_SYSEX_LEN: begin
                        n_vacc = va; n_fcnt = vc;
                        if (vdone) begin
                            n_skip = va;
                            if (va == '0) evend = 1'b1;
                            else n_phase = mfep_pkg::PH_SKIP;
                        end
                    end
                    mfep_pkg::PH_SKIP: begin
                        n_skip = n_skip - 28'd1;
                        if (n_skip == '0) evend = 1'b1;
                    end
                    mfep_pkg::PH_DATA1: begin
                        n_held = b;
                        if (n_cur[7:4] == mfep_pkg::HI_PROG ||
                            n_cur[7:4] == mfep_pkg::HI_PRESS) begin
                            res[nres].result_kind = mfep_pkg::KIND_CHANNEL;
                            res[nres].event_tick  = n_tick;
                            res[nres].status_byte = n_cur;
                            res[nres].first_data  = b;
                            nres = nres + 2'd1;
                            evend = 1'b1;
                        end else n_phase = mfep_pkg::PH_DATA2;
                    end
                    mfep_pkg::PH_DATA2: begin
                        res[nres].result_kind = mfep_pkg::KIND_CHANNEL;
                        res[nres].event_tick  = n_tick;
                        res[nres].status_byte = n_cur;
                        res[nres].first_data  = n_held;
                        res[nres].second_data = b;
                        nres = nres + 2'd1;
                        evend = 1'b1;
                    end
                    default: begin
                    end
                endcase
                if (meta_fin) begin
                    if (n_meta == mfep_pkg::META_TEMPO) begin
                        res[nres].result_kind = mfep_pkg::KIND_TEMPO;
                        res[nres].event_tick  = n_tick;
                        res[nres].tempo_value = n_tempo;
                        nres = nres + 2'd1;
                    end
                    if (n_meta == mfep_pkg::META_EOT) trkend = 1'b1;
                    else evend = 1'b1;
                end
                if (evend) begin
                    if (n_left == '0) trkend = 1'b1;
                    else begin
                        n_phase = mfep_pkg::PH_DELTA; n_vacc = '0; n_fcnt = '0;
                    end
                end
                if (trkend) begin
                    if (n_tick > n_max) n_max = n_tick;
                    res[nres].result_kind = mfep_pkg::KIND_TRK_DONE;
                    res[nres].event_tick  = n_tick;
                    nres = nres + 2'd1;
                    n_trks = n_trks - 16'd1;
                    if (n_trks == '0) begin
                        res[nres].result_kind = mfep_pkg::KIND_COMPLETE;
                        res[nres].event_tick  = n_max;
                        nres = nres + 2'd1;
                        n_phase = mfep_pkg::PH_IDLE;
                    end else begin
                        n_phase = mfep_pkg::PH_TRK_ID; n_fcnt = '0; n_held = '0;
                    end
                end
            end
        end
        if (nres != '0) res[nres - 2'd1].last_result = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= mfep_pkg::PH_HDR_ID; r_fcnt <= '0; r_run <= '0; r_cur <= '0;
            r_held <= '0; r_tick <= '0; r_max <= '0; r_vacc <= '0; r_left <= '0;
            r_trks <= '0; r_skip <= '0; r_meta <= '0; r_tempo <= mfep_pkg::TEMPO_DEF;
        end else if (i_take) begin
            r_phase <= n_phase; r_fcnt <= n_fcnt; r_run <= n_run; r_cur <= n_cur;
            r_held <= n_held; r_tick <= n_tick; r_max <= n_max; r_vacc <= n_vacc;
            r_left <= n_left; r_trks <= n_trks; r_skip <= n_skip; r_meta <= n_meta;
            r_tempo <= n_tempo;
        end
    end

    assign o_group.count = nres;
    assign o_group.r0    = res[0];
    assign o_group.r1    = res[1];
    assign o_group.r2    = res[2];

endmodule

>>> rtl/core/mfep_back.sv
// ----------------------------------------------------------------------------
// MIDI file parser result queue
// Holds result groups from the front end and hands out single results.
// ----------------------------------------------------------------------------
module mfep_back #(
    parameter int DEPTH = mfep_pkg::QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  mfep_pkg::t_res_group  i_group,
    output logic                  o_full,
    output logic                  o_empty,
    output mfep_pkg::t_out_item   o_item,
    input  logic                  i_pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    mfep_pkg::t_res_group  r_mem [DEPTH];
    logic [AW-1:0]         r_wp, r_rp;
    logic [AW:0]           r_cnt;
    logic [1:0]            r_sub;
    mfep_pkg::t_res_group  head;
    logic                  wr_en, rd_done;

    assign head    = r_mem[r_rp];
    assign wr_en   = i_wr && (i_group.count != 2'd0);
    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign rd_done = i_pop && !o_empty && (r_sub + 2'd1 == head.count);

    always_comb begin
        case (r_sub)
            2'd0:    o_item = head.r0;
            2'd1:    o_item = head.r1;
            default: o_item = head.r2;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_wp] <= i_group;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0; r_sub <= '0;
        end else begin
            if (wr_en) r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            if (rd_done) begin
                r_rp  <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
                r_sub <= '0;
            end else if (i_pop && !o_empty) begin
                r_sub <= r_sub + 2'd1;
            end
            r_cnt <= r_cnt + (AW+1)'(wr_en) - (AW+1)'(rd_done);
        end
    end

endmodule

>>> rtl/core/midi_file_event_parser_core.sv
// ----------------------------------------------------------------------------
// MIDI file event parser core
// Parses a Standard MIDI File byte stream into channel, tempo and track results.
// ----------------------------------------------------------------------------
// Channel  | Direction | Handshake          | Payload
// input    | in        | i_push / o_full    | i_in   (data_byte, file_start)
// result   | out       | o_empty / i_pop    | o_out  (kind, tick, data, ...)
//
// One byte is taken per cycle while o_full is low; its up to three results enter the queue as one
// group in the same edge and leave one per cycle while i_pop is high. The queue depth sets how far
// the input runs ahead of a stalled reader. Synchronous reset, no clearing pass.
// ----------------------------------------------------------------------------
module midi_file_event_parser_core #(
    parameter int VARLEN_MAX_BYTES = mfep_pkg::VARLEN_MAX_BYTES_DEF,
    parameter int QUEUE_DEPTH      = mfep_pkg::QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  mfep_pkg::t_in_item   i_in,
    output logic                 o_empty,
    input  logic                 i_pop,
    output mfep_pkg::t_out_item  o_out
);

    mfep_pkg::t_res_group  group;
    logic                  take;

    assign take = i_push && !o_full;

    mfep_front #(.VARLEN_MAX_BYTES(VARLEN_MAX_BYTES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(take), .i_item(i_in), .o_group(group)
    );

    mfep_back #(.DEPTH(QUEUE_DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(take), .i_group(group),
        .o_full(o_full), .o_empty(o_empty), .o_item(o_out), .i_pop(i_pop)
    );

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI file event parser core testbench
// Streams directed and random MIDI files into the parser and compares every
// result against an in-bench prediction, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
    import mfep_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_push;
    logic      o_full;
    t_in_item  i_in;
    logic      o_empty;
    logic      i_pop;
    t_out_item o_out;

    midi_file_event_parser_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .o_full  (o_full),
        .i_in    (i_in),
        .o_empty (o_empty),
        .i_pop   (i_pop),
        .o_out   (o_out)
    );

    // Parser state mirror.
    logic [4:0]  ph;
    logic [2:0]  fcnt;
    logic [7:0]  run_st;
    logic [7:0]  cur_st;
    logic [7:0]  held;
    logic [31:0] trk_tick;
    logic [31:0] song_max;
    logic [27:0] vl_acc;
    logic [31:0] bytes_left;
    logic [15:0] trk_left;
    logic [27:0] skip_n;
    logic [7:0]  meta_k;
    logic [23:0] tempo_acc;
    logic [14:0] tpq;

    t_out_item exp_results[$];
    t_out_item step_res[$];
    t_in_item  pend_bytes[$];
    bit        pend_drain[$];
    logic [7:0] file_q[$];
    logic [7:0] trk_q[$];

    int  errors;
    int  bytes_sent;
    int  total_bytes;
    bit  gen_done;
    int  tx_gap;
    int  rx_gap;
    int  rx_hold;
    bit  held_once;

    task automatic file_put(input logic [7:0] v);
        file_q.insert(file_q.size(), v);
    endtask

    task automatic trk_put(input logic [7:0] v);
        trk_q.insert(trk_q.size(), v);
    endtask

    task automatic parser_clear();
        ph = PH_HDR_ID; fcnt = 0; run_st = 0; cur_st = 0; held = 0;
        trk_tick = 0; song_max = 0; vl_acc = 0; bytes_left = 0; trk_left = 0;
        skip_n = 0; meta_k = 0; tempo_acc = TEMPO_DEF; tpq = 0;
    endtask

    task automatic add_result(input logic [2:0] k, input logic [31:0] t,
                              input logic [7:0] s, input logic [7:0] d1,
                              input logic [7:0] d2, input logic [23:0] tv,
                              input logic [15:0] hv);
        t_out_item r;
        if (step_res.size() < 3) begin
            r = '{k, t, s, d1, d2, tv, hv, 1'b0};
            step_res.insert(step_res.size(), r);
        end
    endtask

    function automatic bit vl_take(input logic [7:0] b);
        vl_acc = {vl_acc[20:0], b[6:0]};
        fcnt = fcnt + 1;
        return (b[7] == 1'b0) || (fcnt >= 4);
    endfunction

    task automatic track_count_off();
        trk_left = trk_left - 1;
        if (trk_left == 0) begin
            add_result(KIND_COMPLETE, song_max, 0, 0, 0, 0, 0);
            ph = PH_IDLE;
        end else begin
            ph = PH_TRK_ID; fcnt = 0; held = 0;
        end
    endtask

    task automatic track_close();
        if (trk_tick > song_max) song_max = trk_tick;
        add_result(KIND_TRK_DONE, trk_tick, 0, 0, 0, 0, 0);
        track_count_off();
    endtask

    task automatic event_close();
        if (bytes_left == 0) begin
            track_close();
        end else begin
            ph = PH_DELTA; vl_acc = 0; fcnt = 0;
        end
    endtask

    task automatic meta_close();
        if (meta_k == META_TEMPO) add_result(KIND_TEMPO, trk_tick, 0, 0, 0, tempo_acc, 0);
        if (meta_k == META_EOT) track_close();
        else event_close();
    endtask

    task automatic track_step(input logic [7:0] b, output bit again);
        logic [32:0] sum;
        again = 0;
        case (ph)
            PH_DELTA: begin
                if (vl_take(b)) begin
                    sum = {1'b0, trk_tick} + {5'd0, vl_acc};
                    trk_tick = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    ph = PH_STATUS;
                end
            end
            PH_STATUS: begin
                if (b[7]) begin
                    run_st = b; cur_st = b;
                end else begin
                    cur_st = run_st;
                end
                if (cur_st == ST_META) ph = PH_META_TYPE;
                else if (cur_st == ST_SYSEX || cur_st == ST_SYSEX_E) begin
                    ph = PH_SYSEX_LEN; vl_acc = 0; fcnt = 0;
                end else ph = PH_DATA1;
                again = !b[7];
            end
            PH_META_TYPE: begin
                meta_k = b; ph = PH_META_LEN; vl_acc = 0; fcnt = 0;
            end
            PH_META_LEN: begin
                if (vl_take(b)) begin
                    skip_n = vl_acc;
                    if (meta_k == META_TEMPO && skip_n < 3) meta_k = 0;
                    tempo_acc = 0; fcnt = 0;
                    if (skip_n == 0) meta_close();
                    else ph = PH_META_DATA;
                end
            end
            PH_META_DATA: begin
                if (meta_k == META_TEMPO && fcnt < 3) begin
                    tempo_acc = {tempo_acc[15:0], b};
                    fcnt = fcnt + 1;
                end
                skip_n = skip_n - 1;
                if (skip_n == 0) meta_close();
            end
            PH_SYSEX_LEN: begin
                if (vl_take(b)) begin
                    skip_n = vl_acc;
                    if (skip_n == 0) event_close();
                    else ph = PH_SKIP;
                end
            end
            PH_SKIP: begin
                skip_n = skip_n - 1;
                if (skip_n == 0) event_close();
            end
            PH_DATA1: begin
                held = b;
                if (cur_st[7:4] == HI_PROG || cur_st[7:4] == HI_PRESS) begin
                    add_result(KIND_CHANNEL, trk_tick, cur_st, b, 0, 0, 0);
                    event_close();
                end else ph = PH_DATA2;
            end
            PH_DATA2: begin
                add_result(KIND_CHANNEL, trk_tick, cur_st, held, b, 0, 0);
                event_close();
            end
            default: ;
        endcase
    endtask

    task automatic predict_byte(input t_in_item it);
        logic [7:0]  b;
        logic [15:0] w;
        bit          again;
        b = it.data_byte;
        step_res.delete();
        if (it.file_start) parser_clear();
        case (ph)
            PH_HDR_ID: begin
                if (b != hdr_char(fcnt[1:0])) begin
                    add_result(KIND_BAD_HDR, 0, 0, 0, 0, 0, 0);
                    ph = PH_IDLE;
                end else begin
                    fcnt = fcnt + 1;
                    if (fcnt >= 4) begin fcnt = 0; ph = PH_HDR_LEN; end
                end
            end
            PH_HDR_LEN: begin
                fcnt = fcnt + 1;
                if (fcnt >= 4) begin fcnt = 0; ph = PH_FORMAT; end
            end
            PH_FORMAT: begin
                fcnt = fcnt + 1;
                if (fcnt >= 2) begin fcnt = 0; ph = PH_NTRK; end
            end
            PH_NTRK: begin
                trk_left = {trk_left[7:0], b};
                fcnt = fcnt + 1;
                if (fcnt >= 2) begin fcnt = 0; ph = PH_DIV; end
            end
            PH_DIV: begin
                if (fcnt == 0) begin
                    held = b; fcnt = 1;
                end else begin
                    fcnt = 0;
                    w = {held, b};
                    held = 0;
                    if (w[15]) begin
                        add_result(KIND_TIMECODE, 0, 0, 0, 0, 0, w);
                        ph = PH_IDLE;
                    end else begin
                        tpq = w[14:0];
                        add_result(KIND_HDR_OK, 0, 0, 0, 0, 0, {1'b0, tpq});
                        if (trk_left == 0) begin
                            add_result(KIND_COMPLETE, song_max, 0, 0, 0, 0, 0);
                            ph = PH_IDLE;
                        end else ph = PH_TRK_ID;
                    end
                end
            end
            PH_TRK_ID: begin
                if (b != trk_char(fcnt[1:0])) held = 1;
                fcnt = fcnt + 1;
                if (fcnt >= 4) begin
                    fcnt = 0;
                    if (held != 0) begin
                        held = 0;
                        track_count_off();
                    end else begin
                        bytes_left = 0; ph = PH_TRK_LEN;
                    end
                end
            end
            PH_TRK_LEN: begin
                bytes_left = {bytes_left[23:0], b};
                fcnt = fcnt + 1;
                if (fcnt >= 4) begin
                    fcnt = 0; trk_tick = 0; run_st = 0; cur_st = 0;
                    event_close();
                end
            end
            PH_IDLE: ;
            default: begin
                if (ph > PH_DATA2) begin
                    ph = PH_IDLE;
                end else begin
                    if (bytes_left != 0) bytes_left = bytes_left - 1;
                    track_step(b, again);
                    if (again) track_step(b, again);
                end
            end
        endcase
        if (step_res.size() > 0) step_res[step_res.size() - 1].last_result = 1'b1;
        foreach (step_res[i]) exp_results.insert(exp_results.size(), step_res[i]);
    endtask

    // File building.
    task automatic put_vlq(input logic [27:0] v);
        logic [6:0] g[4];
        int n;
        n = 1;
        for (int i = 0; i < 4; i++) g[i] = v[i*7 +: 7];
        for (int i = 1; i < 4; i++) if (v >> (7 * i) != 0) n = i + 1;
        for (int i = n - 1; i >= 0; i--) trk_put({(i != 0), g[i]});
    endtask

    task automatic put_hdr(input logic [15:0] ntrk, input logic [15:0] div);
        file_q = '{8'h4D, 8'h54, 8'h68, 8'h64};
        repeat (4) file_put(8'($urandom_range(0, 255)));
        repeat (2) file_put(8'($urandom_range(0, 255)));
        file_put(ntrk[15:8]); file_put(ntrk[7:0]);
        file_put(div[15:8]);  file_put(div[7:0]);
    endtask

    // mode 0: exact length, 1: random length, 2: zero length
    task automatic put_track(input int n_events, input bit with_eot, input int mode);
        logic [31:0] len;
        for (int e = 0; e < n_events; e++) begin
            int kind;
            logic [7:0] st;
            kind = $urandom_range(0, 19);
            put_vlq($urandom_range(0, 9) == 0 ? 28'($urandom()) : 28'($urandom_range(0, 200)));
            st = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
            if (kind < 8) begin
                trk_put(st);
                trk_put(8'($urandom_range(0, 127)));
                if (st[7:4] != HI_PROG && st[7:4] != HI_PRESS)
                    trk_put(8'($urandom_range(0, 127)));
            end else if (kind < 11) begin
                trk_put(8'($urandom_range(0, 127)));
                trk_put(8'($urandom_range(0, 127)));
            end else if (kind < 14) begin
                int ml;
                ml = $urandom_range(0, 4) == 0 ? $urandom_range(0, 5) : 3;
                trk_put(ST_META); trk_put(META_TEMPO);
                put_vlq(28'(ml));
                repeat (ml) trk_put(8'($urandom_range(0, 255)));
            end else if (kind < 16) begin
                int ml;
                ml = $urandom_range(0, 4);
                trk_put(ST_META); trk_put(8'($urandom_range(0, 127)));
                put_vlq(28'(ml));
                repeat (ml) trk_put(8'($urandom_range(0, 255)));
            end else if (kind < 18) begin
                int ml;
                ml = $urandom_range(0, 4);
                trk_put($urandom_range(0, 1) ? ST_SYSEX : ST_SYSEX_E);
                put_vlq(28'(ml));
                repeat (ml) trk_put(8'($urandom_range(0, 255)));
            end else begin
                trk_put(8'($urandom_range(0, 255)));
            end
        end
        if (with_eot) begin
            put_vlq(28'($urandom_range(0, 50)));
            trk_put(ST_META); trk_put(META_EOT); trk_put(8'h00);
        end
        len = (mode == 2) ? 0 :
              (mode == 1) ? $urandom_range(0, trk_q.size() + 3) : trk_q.size();
        file_put(8'h4D); file_put(8'h54);
        file_put(8'h72); file_put(8'h6B);
        for (int i = 3; i >= 0; i--) file_put(len[i*8 +: 8]);
        foreach (trk_q[i]) file_put(trk_q[i]);
        trk_q.delete();
    endtask

    task automatic send_file(input bit drain_first, input bit noisy_restart);
        t_in_item it;
        foreach (file_q[i]) begin
            it.data_byte  = file_q[i];
            it.file_start = (i == 0) || (noisy_restart && $urandom_range(0, 60) == 0);
            pend_bytes.insert(pend_bytes.size(), it);
            pend_drain.insert(pend_drain.size(), drain_first && i == 0);
        end
        total_bytes += file_q.size();
        file_q.delete();
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    // Driver.
    always @(posedge i_clk) begin
        bit quiet;
        if (!i_rst_n) begin
            i_push <= 1'b0;
            i_in   <= '0;
            tx_gap <= 0;
        end else begin
            if (i_push && !o_full) begin
                predict_byte(i_in);
                bytes_sent++;
            end
            quiet = gen_done && (bytes_sent > total_bytes * 85 / 100);
            if (i_push && o_full) begin
            end else if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                i_push <= 1'b0;
            end else if (pend_bytes.size() == 0 ||
                         (pend_drain[0] && exp_results.size() != 0)) begin
                i_push <= 1'b0;
            end else if (!quiet && $urandom_range(0, 11) == 0) begin
                tx_gap <= $urandom_range(0, 10);
                i_push <= 1'b0;
            end else begin
                i_push <= 1'b1;
                i_in   <= pend_bytes.pop_front();
                void'(pend_drain.pop_front());
            end
        end
    end

    // Long receiver hold-off while the sender keeps going.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_hold   <= 0;
            held_once <= 1'b0;
        end else if (!held_once && bytes_sent >= 60) begin
            rx_hold   <= 150;
            held_once <= 1'b1;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
        end
    end

    // Monitor and result checker.
    always @(posedge i_clk) begin
        t_out_item want;
        bit quiet;
        if (!i_rst_n) begin
            i_pop  <= 1'b0;
            rx_gap <= 0;
        end else begin
            if (i_pop && !o_empty) begin
                if (exp_results.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, o_out);
                    errors++;
                end else begin
                    want = exp_results.pop_front();
                    if (o_out !== want) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, o_out);
                        errors++;
                    end
                end
            end
            quiet = gen_done && (bytes_sent > total_bytes * 85 / 100);
            if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                i_pop  <= 1'b0;
            end else if (!quiet && $urandom_range(0, 11) == 0) begin
                rx_gap <= $urandom_range(0, 10);
                i_pop  <= 1'b0;
            end else begin
                i_pop <= (rx_hold == 0);
            end
        end
    end

    initial begin
        int wait_cycles;
        errors = 0; bytes_sent = 0; total_bytes = 0; gen_done = 0;
        i_rst_n = 1'b0;
        parser_clear();

        // Bad header identifier.
        file_q = '{8'h4D, 8'h54, 8'h58, 8'h64, 8'h00};
        send_file(0, 0);
        // Timecode division.
        put_hdr(16'd1, 16'hE728);
        send_file(0, 0);
        // No tracks at all.
        put_hdr(16'd0, 16'h0060);
        send_file(0, 0);
        // Wrong track identifier, zero length track, then one with running status and data in status
        // position that ends in end of track at its exact length.
        put_hdr(16'd4, 16'h7FFF);
        file_put(8'h4D); file_put(8'h54);
        file_put(8'h52); file_put(8'h6B);
        put_track(0, 0, 2);
        trk_q = '{8'h00, 8'h90, 8'h3C, 8'h7F, 8'h05, 8'h40, 8'h00, 8'h00, 8'hC3, 8'h7F,
                  8'h00, 8'hFF, 8'h51, 8'h03, 8'h07, 8'hA1, 8'h20,
                  8'h00, 8'hFF, 8'h51, 8'h02, 8'h01, 8'h02,
                  8'h00, 8'hFF, 8'h2F, 8'h00};
        put_track(0, 0, 0);
        file_put(8'h4D); file_put(8'h54);
        file_put(8'h72); file_put(8'h6B);
        send_file(0, 0);
        // Saturating tick, over-long delta and running status zero.
        put_hdr(16'd1, 16'h0000);
        trk_put(8'hFF); trk_put(8'hFF); trk_put(8'hFF); trk_put(8'h7F);
        trk_put(8'hD1); trk_put(8'h10);
        repeat (16) begin
            trk_put(8'hFF); trk_put(8'hFF);
            trk_put(8'hFF); trk_put(8'h7F);
            trk_put(8'h10);
        end
        trk_put(8'h81); trk_put(8'h80); trk_put(8'h80);
        trk_put(8'h80); trk_put(8'h00); trk_put(8'h11);
        put_track(0, 1, 0);
        send_file(0, 0);
        file_q = '{8'h4D, 8'h54, 8'h68, 8'h64, 0, 0, 0, 6, 0, 1, 0, 1, 0, 8'h60,
                   8'h4D, 8'h54, 8'h72, 8'h6B, 0, 0, 0, 3, 8'h00, 8'h20, 8'h30};
        send_file(0, 0);

        // Random files, mostly well formed.
        while (total_bytes < 260) begin
            int nt;
            nt = $urandom_range(1, 3);
            put_hdr(16'(nt), $urandom_range(0, 15) == 0 ? 16'($urandom()) :
                    16'($urandom_range(1, 960)));
            for (int t = 0; t < nt; t++)
                put_track($urandom_range(0, 6), $urandom_range(0, 3) != 0,
                          $urandom_range(0, 5) == 0 ? $urandom_range(1, 2) : 0);
            if ($urandom_range(0, 7) == 0) file_q[$urandom_range(0, file_q.size() - 1)]
                = 8'($urandom_range(0, 255));
            send_file($urandom_range(0, 9) == 0, 1);
        end
        gen_done = 1;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pend_bytes.size() == 0);
        @(posedge i_clk);
        while (i_push || exp_results.size() != 0) @(posedge i_clk);
        wait_cycles = 0;
        while (wait_cycles < 20) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        foreach (exp_results[i])
            $display("%0t: missing result expected %p actual none", $time, exp_results[i]);
        errors += exp_results.size();
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
